[hw/rtl/ctps_pkg.sv]
// Package for the camera trigger pulse sequencer: request codes, command codes,
// register indexes, reset values and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctps_pkg;

  localparam int unsigned MsW = 16;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_SET_CAM   = 3'd1,
    REQ_SET_SENS  = 3'd2,
    REQ_START     = 3'd3,
    REQ_STOP      = 3'd4,
    REQ_PHOTO     = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ACT_IDLE      = 3'd0,
    ACT_CAM_ONCE  = 3'd1,
    ACT_CAM_TWICE = 3'd2,
    ACT_SENSOR    = 3'd3,
    ACT_STARTSTOP = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    CAM_VIDEO  = 2'd0,
    CAM_SERIAL = 2'd1,
    CAM_PHOTO  = 2'd2
  } cam_mode_t;

  typedef enum logic [1:0] {
    REG_CAM_PULSE   = 2'd0,
    REG_SENS_PULSE  = 2'd1,
    REG_SS_PULSE    = 2'd2,
    REG_COOLDOWN    = 2'd3
  } reg_idx_t;

  localparam logic [MsW-1:0] CamPulseRst  = 16'd500;
  localparam logic [MsW-1:0] SensPulseRst = 16'd500;
  localparam logic [MsW-1:0] SsPulseRst   = 16'd500;
  localparam logic [MsW-1:0] CooldownRst  = 16'd200;

  typedef struct packed {
    logic [MsW-1:0] cam_pulse;
    logic [MsW-1:0] sens_pulse;
    logic [MsW-1:0] ss_pulse;
    logic [MsW-1:0] cooldown;
  } cfg_t;

  // Packed so that the last field sits in the lowest bits.
  typedef struct packed {
    logic       recording;
    logic       sensor_flipped;
    logic [1:0] camera_mode;
    logic       busy_res;
    logic       line_high;
    logic       accepted;
  } result_t;

  // The camera steps video -> serial -> photo -> video on each pulse.
  function automatic logic [1:0] next_cam(input logic [1:0] m);
    logic [1:0] r;
    unique case (m)
      CAM_SERIAL: r = CAM_PHOTO;
      CAM_PHOTO:  r = CAM_VIDEO;
      default:    r = CAM_SERIAL;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ctps_cfg_regs.sv]
// Configuration register file of the camera trigger pulse sequencer.
// Depends on ctps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctps_cfg_regs (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [1:0]            wr_index,
  input  wire logic [15:0]           wr_data,
  output ctps_pkg::cfg_t             cfg
);

  ctps_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cam_pulse  <= ctps_pkg::CamPulseRst;
      cfg_r.sens_pulse <= ctps_pkg::SensPulseRst;
      cfg_r.ss_pulse   <= ctps_pkg::SsPulseRst;
      cfg_r.cooldown   <= ctps_pkg::CooldownRst;
    end else if (wr_en) begin
      unique case (ctps_pkg::reg_idx_t'(wr_index))
        ctps_pkg::REG_CAM_PULSE:  cfg_r.cam_pulse  <= wr_data;
        ctps_pkg::REG_SENS_PULSE: cfg_r.sens_pulse <= wr_data;
        ctps_pkg::REG_SS_PULSE:   cfg_r.ss_pulse   <= wr_data;
        ctps_pkg::REG_COOLDOWN:   cfg_r.cooldown   <= wr_data;
        default:                  cfg_r.cooldown   <= wr_data;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hw/rtl/ctps_seq.sv]
// Command sequencer state and its single-pass update for one transaction.
// Holds the mirrored camera state and the pulse timing. Depends on ctps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctps_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire logic [2:0]            cmd,
  input  wire logic [1:0]            mode_arg,
  input  wire logic [15:0]           now_ms,
  input  ctps_pkg::cfg_t             cfg,
  output ctps_pkg::result_t          res
);

  ctps_pkg::act_t act_r, act_nxt;
  logic [15:0]    plen_r, plen_nxt;
  logic [15:0]    pstart_r, pstart_nxt;
  logic           line_r, line_nxt;
  logic           cool_r, cool_nxt;
  logic [1:0]     cam_r, cam_nxt;
  logic           sens_r, sens_nxt;
  logic           rec_r, rec_nxt;

  logic           busy;
  logic           ok;
  logic [15:0]    delta;
  logic [16:0]    end_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= ctps_pkg::ACT_IDLE;
      plen_r   <= '0;
      pstart_r <= '0;
      line_r   <= 1'b0;
      cool_r   <= 1'b0;
      cam_r    <= ctps_pkg::CAM_VIDEO;
      sens_r   <= 1'b0;
      rec_r    <= 1'b0;
    end else if (step_en) begin
      act_r    <= act_nxt;
      plen_r   <= plen_nxt;
      pstart_r <= pstart_nxt;
      line_r   <= line_nxt;
      cool_r   <= cool_nxt;
      cam_r    <= cam_nxt;
      sens_r   <= sens_nxt;
      rec_r    <= rec_nxt;
    end
  end

  assign busy    = (act_r != ctps_pkg::ACT_IDLE);
  assign delta   = now_ms - pstart_r;
  assign end_sum = {1'b0, plen_r} + {1'b0, cfg.cooldown};

  always_comb begin
    act_nxt    = act_r;
    plen_nxt   = plen_r;
    pstart_nxt = pstart_r;
    line_nxt   = line_r;
    cool_nxt   = cool_r;
    cam_nxt    = cam_r;
    sens_nxt   = sens_r;
    rec_nxt    = rec_r;
    ok         = 1'b0;

    unique case (cmd)
      ctps_pkg::REQ_TICK: begin
        ok = 1'b1;
        if (busy) begin
          if (!line_r && !cool_r) begin
            line_nxt   = 1'b1;
            pstart_nxt = now_ms;
          end else if (delta >= plen_r) begin
            if (!cool_r) begin
              // End of the high phase: the camera has taken the step.
              line_nxt = 1'b0;
              cool_nxt = 1'b1;
              unique case (act_r)
                ctps_pkg::ACT_CAM_ONCE,
                ctps_pkg::ACT_CAM_TWICE: cam_nxt = ctps_pkg::next_cam(cam_r);
                ctps_pkg::ACT_SENSOR:    sens_nxt = ~sens_r;
                ctps_pkg::ACT_STARTSTOP: begin
                  if (cam_r != ctps_pkg::CAM_PHOTO) rec_nxt = ~rec_r;
                end
                default: ;
              endcase
            end else if ({1'b0, delta} >= end_sum) begin
              if (act_r == ctps_pkg::ACT_CAM_TWICE) begin
                act_nxt    = ctps_pkg::ACT_CAM_ONCE;
                pstart_nxt = now_ms;
              end else begin
                act_nxt = ctps_pkg::ACT_IDLE;
              end
              cool_nxt = 1'b0;
            end
          end
        end
      end
      ctps_pkg::REQ_SET_CAM: begin
        if (mode_arg != 2'd3 && !busy && !rec_r) begin
          ok = 1'b1;
          if (mode_arg != cam_r) begin
            plen_nxt = cfg.cam_pulse;
            act_nxt  = (mode_arg == ctps_pkg::next_cam(cam_r)) ?
                       ctps_pkg::ACT_CAM_ONCE : ctps_pkg::ACT_CAM_TWICE;
          end
        end
      end
      ctps_pkg::REQ_SET_SENS: begin
        if (!mode_arg[1] && !busy && !rec_r) begin
          ok = 1'b1;
          if (mode_arg[0] != sens_r) begin
            plen_nxt = cfg.sens_pulse;
            act_nxt  = ctps_pkg::ACT_SENSOR;
          end
        end
      end
      ctps_pkg::REQ_START: begin
        if (!busy && !rec_r && cam_r != ctps_pkg::CAM_PHOTO) begin
          ok       = 1'b1;
          plen_nxt = cfg.ss_pulse;
          act_nxt  = ctps_pkg::ACT_STARTSTOP;
        end
      end
      ctps_pkg::REQ_STOP: begin
        if (!busy && rec_r && cam_r != ctps_pkg::CAM_PHOTO) begin
          ok       = 1'b1;
          plen_nxt = cfg.ss_pulse;
          act_nxt  = ctps_pkg::ACT_STARTSTOP;
        end
      end
      ctps_pkg::REQ_PHOTO: begin
        if (!busy && cam_r == ctps_pkg::CAM_PHOTO) begin
          ok       = 1'b1;
          plen_nxt = cfg.ss_pulse;
          act_nxt  = ctps_pkg::ACT_STARTSTOP;
        end
      end
      default: ;
    endcase

    res.accepted       = ok;
    res.line_high      = line_nxt;
    res.busy_res       = (act_nxt != ctps_pkg::ACT_IDLE);
    res.camera_mode    = cam_nxt;
    res.sensor_flipped = sens_nxt;
    res.recording      = rec_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/camera_trigger_pulse_sequencer_core.sv]
// Camera trigger pulse sequencer: the request stream enters an input register,
// one pass of logic updates the mirrored camera state, and the status leaves in
// an output register. The input channel carries requests and millisecond ticks.
// in_tdata fields from bit 0: cmd[2:0], mode_arg[4:3], now_ms[20:5].
// out_tdata fields from bit 0: accepted, line_high, busy_res, camera_mode[4:3],
// sensor_flipped, recording.
// The cfg_ channel writes the four timing registers; cfg_ready is always high,
// and writes are expected only while no transaction is in flight.
// A transaction accepted into the input register passes the state update and has
// its status in the output register, which drives out_tvalid; one transaction is
// taken every cycle while the receiver does not stall, set by the single state update between the two registers.
// When the receiver stalls, the output register holds its result; the input register
// still takes a transaction if it is empty, and in_tready stays low while it holds one.
// Synchronous reset clears both registers' valid flags, returns the mirror to
// video, normal and not recording, and reloads the default timings.
// Depends on ctps_pkg, ctps_cfg_regs and ctps_seq.
`timescale 1ns / 1ps
`default_nettype none

module camera_trigger_pulse_sequencer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [23:0] in_tdata,   // cmd[2:0], mode_arg[4:3], now_ms[20:5]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [7:0]  out_tdata,  // accepted, line_high, busy_res,
                                       // camera_mode[4:3], sensor_flipped, recording
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic              in_vld_r;
  logic [20:0]       in_dat_r;
  logic              out_vld_r;
  ctps_pkg::result_t out_res_r;
  logic              adv;
  ctps_pkg::cfg_t    cfg;
  ctps_pkg::result_t res;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) in_vld_r <= in_tvalid;
      if (adv) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_dat_r <= in_tdata[20:0];
    if (adv) out_res_r <= res;
  end

  ctps_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ctps_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (adv),
    .cmd      (in_dat_r[2:0]),
    .mode_arg (in_dat_r[4:3]),
    .now_ms   (in_dat_r[20:5]),
    .cfg      (cfg),
    .res      (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_res_r};

endmodule

`default_nettype wire

[hw/rtl/ctps_checker.sv]
// Port-level checker for camera_trigger_pulse_sequencer_core, with its bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module ctps_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // The line is only high while a command runs.
  a_line_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[2])
    else $error("line high while idle");

  // Recording can never coexist with photo mode, and mode 3 never appears.
  a_rec_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> out_tdata[4:3] != 2'd2)
    else $error("recording in photo mode");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:3] != 2'd3)
    else $error("camera mode out of range");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind camera_trigger_pulse_sequencer_core ctps_checker u_ctps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
